@@ rtl/core/wbgs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// White balance gain stepper package
// Shared types and constants for the gain stepper and its divider.
// ----------------------------------------------------------------------------
package wbgs_pkg;

   localparam int unsigned OperandWidth = 16;
   localparam int unsigned GainWidth    = 8;
   localparam int unsigned WideWidth    = 18;

   localparam logic [GainWidth-1:0] RbCap = 8'd135;
   localparam logic [GainWidth-1:0] GCap  = 8'd128;

   localparam logic [2:0] RegTargetX     = 3'd0;
   localparam logic [2:0] RegTargetY     = 3'd1;
   localparam logic [2:0] RegToleranceX  = 3'd2;
   localparam logic [2:0] RegToleranceY  = 3'd3;
   localparam logic [2:0] RegXStepDiv    = 3'd4;
   localparam logic [2:0] RegYStepDiv    = 3'd5;
   localparam logic [2:0] RegGainMin     = 3'd6;
   localparam logic [2:0] RegGainMax     = 3'd7;

   localparam logic [2:0] Phase1 = 3'd1;
   localparam logic [2:0] Phase2 = 3'd2;
   localparam logic [2:0] Phase3 = 3'd3;
   localparam logic [2:0] Phase4 = 3'd4;

   typedef struct packed {
      logic                    start;
      logic [OperandWidth-1:0] dividend;
      logic [OperandWidth-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic [OperandWidth-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

@@ rtl/core/white_balance_gain_stepper.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// White balance gain stepper
// Steps red, green and blue gains toward a target chromaticity.
// ----------------------------------------------------------------------------
// An adjust transaction passes the x and y errors in turn through one shared
// 16-step restoring divider, and the new gains are then worked out in the
// apply state. Load transactions and inactive phases skip the divider and go
// straight to the apply state. A new request is taken once the previous
// result has been written to the response register, and a response stall
// while that register is still full holds the block in the apply state.
module white_balance_gain_stepper
   import wbgs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_mode,
   input  wire logic [2:0]  req_phase,
   input  wire logic [15:0] req_measured_x,
   input  wire logic [15:0] req_measured_y,
   input  wire logic [7:0]  req_preset_red,
   input  wire logic [7:0]  req_preset_green,
   input  wire logic [7:0]  req_preset_blue,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_red_out,
   output logic [7:0]       rsp_green_out,
   output logic [7:0]       rsp_blue_out,
   output logic [2:0]       rsp_next_phase,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAIT_X,
      ST_WAIT_Y,
      ST_APPLY
   } state_type;

   typedef logic signed [WideWidth-1:0] wide_type;

   state_type state_ff;

   logic [15:0] target_x_ff, target_y_ff, tolerance_x_ff, tolerance_y_ff;
   logic [15:0] x_div_ff, y_div_ff;
   logic [7:0]  gain_min_ff, gain_max_ff;
   logic [7:0]  red_gain_ff, green_gain_ff, blue_gain_ff;

   logic        mode_ff;
   logic [2:0]  phase_ff;
   logic [7:0]  preset_red_ff, preset_green_ff, preset_blue_ff;
   logic        x_low_ff, x_high_ff, y_low_ff, y_high_ff;
   logic        x_neg_ff, y_neg_ff;
   logic [15:0] abs_y_ff, div_y_ff;
   wide_type    qx_ff, qy_ff;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic [2:0]  rsp_phase_ff;

   div_req_type div_req_ff;
   div_rsp_type div_rsp;

   logic        accept;
   logic        active;
   wide_type    mx_w, my_w, sx_w, sy_w;
   logic [16:0] diff_x, diff_y;
   logic [15:0] abs_x, abs_y;
   logic        x_low, x_high, y_low, y_high;
   wide_type    quo_w;

   logic [7:0]  red_in, green_in, blue_in;
   logic [2:0]  code_in;

   wbgs_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign active    = req_mode & (req_phase >= Phase1) & (req_phase <= Phase4);
   assign csr_ready = 1'b1;

   assign mx_w = wide_type'({2'b00, req_measured_x});
   assign my_w = wide_type'({2'b00, req_measured_y});
   assign sx_w = wide_type'({2'b00, target_x_ff});
   assign sy_w = wide_type'({2'b00, target_y_ff});

   assign x_low  = mx_w < (sx_w - wide_type'({2'b00, tolerance_x_ff}));
   assign x_high = mx_w > (sx_w + wide_type'({2'b00, tolerance_x_ff}));
   assign y_low  = my_w < (sy_w - wide_type'({2'b00, tolerance_y_ff}));
   assign y_high = my_w > (sy_w + wide_type'({2'b00, tolerance_y_ff}));

   assign diff_x = {1'b0, target_x_ff} - {1'b0, req_measured_x};
   assign diff_y = {1'b0, target_y_ff} - {1'b0, req_measured_y};
   assign abs_x  = diff_x[16] ? 16'(-diff_x) : diff_x[15:0];
   assign abs_y  = diff_y[16] ? 16'(-diff_y) : diff_y[15:0];

   assign quo_w = wide_type'({2'b00, div_rsp.quotient});

   function automatic logic [7:0] clamp_rb(input wide_type v, input logic [7:0] lo,
                                           input logic [7:0] hi);
      logic [7:0] res;
      if (v < wide_type'({10'd0, lo})) begin
         res = lo;
      end else if (v > wide_type'({10'd0, hi})) begin
         res = hi;
      end else begin
         res = v[7:0];
      end
      return res;
   endfunction

   always_comb begin
      wide_type r0, b0, r, g, b;
      wide_type rb_cap_w, g_cap_w;
      r0       = wide_type'({10'd0, red_gain_ff});
      b0       = wide_type'({10'd0, blue_gain_ff});
      r        = r0;
      b        = b0;
      g        = wide_type'({10'd0, green_gain_ff});
      rb_cap_w = wide_type'({10'd0, RbCap});
      g_cap_w  = wide_type'({10'd0, GCap});
      code_in  = phase_ff;
      case (phase_ff)
         Phase1: begin
            if (y_low_ff) begin
               b       = b0 - qy_ff;
               code_in = Phase3;
            end else if (x_low_ff) begin
               r = r0 + qx_ff;
               if (r >= rb_cap_w) begin
                  r       = rb_cap_w;
                  code_in = Phase2;
               end
            end else if (x_high_ff) begin
               r = r0 + qx_ff;
            end else begin
               code_in = Phase2;
            end
         end
         Phase2: begin
            if (g > g_cap_w) g = g_cap_w;
            if (y_low_ff || y_high_ff) g = g + qy_ff;
            if (x_high_ff) begin
               r = r0 + qx_ff;
            end else if (x_low_ff) begin
               r = r0 + qx_ff;
               if (r >= rb_cap_w) begin
                  r       = rb_cap_w;
                  code_in = Phase4;
                  b       = b0 - qx_ff;
               end
            end
         end
         Phase3: begin
            if (y_low_ff) begin
               b = b0 - qy_ff;
            end else if (y_high_ff) begin
               b = b0 - qy_ff;
               if (b >= rb_cap_w) begin
                  b       = rb_cap_w;
                  code_in = Phase1;
               end
            end else if (x_high_ff) begin
               r = r0 + qx_ff;
            end else if (x_low_ff) begin
               r = r0 + qx_ff;
               if (r >= rb_cap_w) begin
                  r       = rb_cap_w;
                  code_in = Phase4;
                  b       = b0 - qx_ff;
               end
            end
         end
         Phase4: begin
            if (x_low_ff || x_high_ff) begin
               b = b0 - qx_ff;
            end else begin
               if (y_low_ff) begin
                  g = g + qy_ff;
                  if (g > g_cap_w) g = g_cap_w;
               end else if (y_high_ff) begin
                  g = g + qy_ff;
               end
               code_in = Phase2;
            end
         end
         default: begin
         end
      endcase

      if (!mode_ff) begin
         red_in   = preset_red_ff;
         green_in = preset_green_ff;
         blue_in  = preset_blue_ff;
         code_in  = phase_ff;
      end else if (phase_ff >= Phase1 && phase_ff <= Phase4) begin
         red_in  = clamp_rb(r, gain_min_ff, gain_max_ff);
         blue_in = clamp_rb(b, gain_min_ff, gain_max_ff);
         if (g < 0) begin
            green_in = 8'd0;
         end else if (g > wide_type'(255)) begin
            green_in = 8'd255;
         end else begin
            green_in = g[7:0];
         end
      end else begin
         red_in   = red_gain_ff;
         green_in = green_gain_ff;
         blue_in  = blue_gain_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_x_ff    <= 16'd2800;
         target_y_ff    <= 16'd2900;
         tolerance_x_ff <= 16'd10;
         tolerance_y_ff <= 16'd10;
         x_div_ff       <= 16'd4;
         y_div_ff       <= 16'd4;
         gain_min_ff    <= 8'd0;
         gain_max_ff    <= 8'd255;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            RegTargetX:    target_x_ff    <= csr_wdata;
            RegTargetY:    target_y_ff    <= csr_wdata;
            RegToleranceX: tolerance_x_ff <= csr_wdata;
            RegToleranceY: tolerance_y_ff <= csr_wdata;
            RegXStepDiv:   x_div_ff       <= csr_wdata;
            RegYStepDiv:   y_div_ff       <= csr_wdata;
            RegGainMin:    gain_min_ff    <= csr_wdata[7:0];
            RegGainMax:    gain_max_ff    <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         div_req_ff.start <= 1'b0;
         red_gain_ff      <= 8'd0;
         green_gain_ff    <= 8'd0;
         blue_gain_ff     <= 8'd0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_APPLY) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               div_req_ff.start <= accept & active;
               if (accept) begin
                  mode_ff         <= req_mode;
                  phase_ff        <= req_phase;
                  preset_red_ff   <= req_preset_red;
                  preset_green_ff <= req_preset_green;
                  preset_blue_ff  <= req_preset_blue;
                  x_low_ff        <= x_low;
                  x_high_ff       <= x_high;
                  y_low_ff        <= y_low;
                  y_high_ff       <= y_high;
                  x_neg_ff        <= diff_x[16];
                  y_neg_ff        <= diff_y[16];
                  abs_y_ff        <= abs_y;
                  div_y_ff        <= (y_div_ff == 16'd0) ? 16'd1 : y_div_ff;
                  if (active) begin
                     div_req_ff.dividend <= abs_x;
                     div_req_ff.divisor  <= (x_div_ff == 16'd0) ? 16'd1 : x_div_ff;
                     state_ff            <= ST_WAIT_X;
                  end else begin
                     state_ff <= ST_APPLY;
                  end
               end
            end
            ST_WAIT_X: begin
               div_req_ff.start <= div_rsp.done;
               if (div_rsp.done) begin
                  qx_ff               <= x_neg_ff ? -quo_w : quo_w;
                  div_req_ff.dividend <= abs_y_ff;
                  div_req_ff.divisor  <= div_y_ff;
                  state_ff            <= ST_WAIT_Y;
               end
            end
            ST_WAIT_Y: begin
               div_req_ff.start <= 1'b0;
               if (div_rsp.done) begin
                  qy_ff    <= y_neg_ff ? -quo_w : quo_w;
                  state_ff <= ST_APPLY;
               end
            end
            ST_APPLY: begin
               div_req_ff.start <= 1'b0;
               if (!rsp_valid_ff || !rsp_stall) begin
                  red_gain_ff   <= red_in;
                  green_gain_ff <= green_in;
                  blue_gain_ff  <= blue_in;
                  rsp_red_ff    <= red_in;
                  rsp_green_ff  <= green_in;
                  rsp_blue_ff   <= blue_in;
                  rsp_phase_ff  <= code_in;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               div_req_ff.start <= 1'b0;
               state_ff         <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red_out    = rsp_red_ff;
   assign rsp_green_out  = rsp_green_ff;
   assign rsp_blue_out   = rsp_blue_ff;
   assign rsp_next_phase = rsp_phase_ff;

endmodule
`default_nettype wire

@@ rtl/core/wbgs_divider.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Gain stepper divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wbgs_divider
   import wbgs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   logic                    busy_ff;
   logic                    done_ff;
   logic [3:0]              count_ff;
   logic [OperandWidth-1:0] rem_ff;
   logic [OperandWidth-1:0] quo_ff;
   logic [OperandWidth-1:0] div_ff;

   logic [OperandWidth:0]   shifted;
   logic [OperandWidth+1:0] trial;
   logic                    fits;

   assign shifted = {rem_ff, quo_ff[OperandWidth-1]};
   assign trial   = {1'b0, shifted} - {2'b00, div_ff};
   assign fits    = ~trial[OperandWidth+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
            rem_ff   <= '0;
            quo_ff   <= div_req.dividend;
            div_ff   <= div_req.divisor;
         end else if (busy_ff) begin
            rem_ff   <= fits ? trial[OperandWidth-1:0] : shifted[OperandWidth-1:0];
            quo_ff   <= {quo_ff[OperandWidth-2:0], fits};
            count_ff <= count_ff + 4'd1;
            if (count_ff == 4'd15) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
`default_nettype wire

@@ test/tb_white_balance_gain_stepper.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// White balance gain stepper testbench
// Sends load and adjust transactions under a range of target, tolerance,
// divisor and gain range settings, mostly with random idling on both sides,
// and compares every result field by field with typed values or a model.
// ----------------------------------------------------------------------------
module tb_white_balance_gain_stepper;
   import wbgs_pkg::*;

   localparam int NumSettings     = 7;
   localparam int ItemsPerSetting = 158;
   localparam int WatchdogLimit   = 5000;
   localparam int RedBlueCap      = int'(RbCap);
   localparam int GreenCap        = int'(GCap);

   localparam logic [2:0] RegOrder [8] = '{RegTargetX, RegTargetY, RegToleranceX,
      RegToleranceY, RegXStepDiv, RegYStepDiv, RegGainMin, RegGainMax};

   typedef struct packed {
      logic        mode;
      logic [2:0]  phase;
      logic [15:0] measured_x;
      logic [15:0] measured_y;
      logic [7:0]  preset_red;
      logic [7:0]  preset_green;
      logic [7:0]  preset_blue;
   } gain_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [2:0] phase;
   } gain_rsp_type;

   typedef struct packed {
      gain_req_type req;
      logic         known;
      gain_rsp_type rsp;
   } directed_row_type;

   // Rows run with the register values left by reset. Results are typed in
   // only where they are plain; the others come from the gain model.
   localparam directed_row_type DirectedRows [25] = '{
      '{'{1'b1, 3'd0, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
        '{8'd0, 8'd0, 8'd0, 3'd0}},
      '{'{1'b1, 3'd7, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
        '{8'd0, 8'd0, 8'd0, 3'd7}},
      '{'{1'b1, 3'd5, 16'd2800, 16'd2900, 8'd1, 8'd2, 8'd3}, 1'b1,
        '{8'd0, 8'd0, 8'd0, 3'd5}},
      '{'{1'b1, 3'd6, 16'd0, 16'hFFFF, 8'd0, 8'd0, 8'd0}, 1'b1,
        '{8'd0, 8'd0, 8'd0, 3'd6}},
      '{'{1'b0, Phase3, 16'hFFFF, 16'd0, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
        '{8'hFF, 8'hFF, 8'hFF, Phase3}},
      '{'{1'b0, 3'd0, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
        '{8'd0, 8'd0, 8'd0, 3'd0}},
      '{'{1'b0, 3'd7, 16'd0, 16'hFFFF, 8'd100, 8'd200, 8'd100}, 1'b1,
        '{8'd100, 8'd200, 8'd100, 3'd7}},
      '{'{1'b1, Phase1, 16'd2800, 16'd2900, 8'd0, 8'd0, 8'd0}, 1'b1,
        '{8'd100, 8'd200, 8'd100, Phase2}},
      '{'{1'b1, Phase1, 16'd2800, 16'd2800, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{1'b1, Phase1, 16'd2700, 16'd2900, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{1'b1, Phase1, 16'd0, 16'd2900, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{1'b1, Phase1, 16'hFFFF, 16'd2900, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{1'b1, Phase2, 16'd2800, 16'd2900, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{1'b0, Phase2, 16'd0, 16'd0, 8'd130, 8'd250, 8'd60}, 1'b1,
        '{8'd130, 8'd250, 8'd60, Phase2}},
      '{'{1'b1, Phase2, 16'd2700, 16'd2800, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{1'b1, Phase2, 16'd2900, 16'hFFFF, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{1'b1, Phase3, 16'd2800, 16'd2000, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{1'b1, Phase3, 16'd2800, 16'd3500, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{1'b1, Phase3, 16'd3100, 16'd2900, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{1'b1, Phase3, 16'd0, 16'd2900, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{1'b1, Phase4, 16'd2000, 16'd2900, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{1'b1, Phase4, 16'hFFFF, 16'd2900, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{1'b1, Phase4, 16'd2805, 16'd0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{1'b1, Phase4, 16'd2795, 16'd3000, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
      '{'{1'b1, Phase1, 16'd2790, 16'd2890, 8'd0, 8'd0, 8'd0}, 1'b0, '0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_mode = 1'b0;
   logic [2:0]  req_phase = 3'd0;
   logic [15:0] req_measured_x = 16'd0;
   logic [15:0] req_measured_y = 16'd0;
   logic [7:0]  req_preset_red = 8'd0;
   logic [7:0]  req_preset_green = 8'd0;
   logic [7:0]  req_preset_blue = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_red_out;
   logic [7:0]  rsp_green_out;
   logic [7:0]  rsp_blue_out;
   logic [2:0]  rsp_next_phase;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = 3'd0;
   logic [15:0] csr_wdata = 16'd0;

   logic [15:0] cfg_target_x = 16'd2800;
   logic [15:0] cfg_target_y = 16'd2900;
   logic [15:0] cfg_tol_x = 16'd10;
   logic [15:0] cfg_tol_y = 16'd10;
   logic [15:0] cfg_x_div = 16'd4;
   logic [15:0] cfg_y_div = 16'd4;
   logic [7:0]  cfg_gain_min = 8'd0;
   logic [7:0]  cfg_gain_max = 8'd255;

   logic [7:0]  gain_red = 8'd0;
   logic [7:0]  gain_green = 8'd0;
   logic [7:0]  gain_blue = 8'd0;
   logic [2:0]  advised_phase = Phase1;

   logic [15:0]  setting_regs [NumSettings][8];
   gain_rsp_type gains_due [$];
   int           mismatch_count = 0;
   bit           steady_flow = 1'b0;

   white_balance_gain_stepper dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_phase        (req_phase),
      .req_measured_x   (req_measured_x),
      .req_measured_y   (req_measured_y),
      .req_preset_red   (req_preset_red),
      .req_preset_green (req_preset_green),
      .req_preset_blue  (req_preset_blue),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_next_phase   (rsp_next_phase),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit take_break();
      return !steady_flow && ($urandom_range(0, 99) < 30);
   endfunction

   function automatic int clamp_red_blue(int v);
      if (v < int'(cfg_gain_min)) return int'(cfg_gain_min);
      if (v > int'(cfg_gain_max)) return int'(cfg_gain_max);
      return v;
   endfunction

   function automatic gain_rsp_type step_gains(gain_req_type t);
      int sx, sy, xt, yt, xd, yd, mx, my, r0, b0, r, g, b;
      int ey_lo, ey_hi, ex_lo, ex_hi;
      bit y_lo, y_hi, x_lo, x_hi;
      logic [2:0] code;
      code = t.phase;
      if (t.mode == 1'b0) begin
         gain_red   = t.preset_red;
         gain_green = t.preset_green;
         gain_blue  = t.preset_blue;
      end else if (t.phase >= Phase1 && t.phase <= Phase4) begin
         sx = int'(cfg_target_x);
         sy = int'(cfg_target_y);
         xt = int'(cfg_tol_x);
         yt = int'(cfg_tol_y);
         xd = (cfg_x_div == 16'd0) ? 1 : int'(cfg_x_div);
         yd = (cfg_y_div == 16'd0) ? 1 : int'(cfg_y_div);
         mx = int'(t.measured_x);
         my = int'(t.measured_y);
         r0 = int'(gain_red);
         b0 = int'(gain_blue);
         r = r0;
         g = int'(gain_green);
         b = b0;
         y_lo = my < sy - yt;
         y_hi = my > sy + yt;
         x_lo = mx < sx - xt;
         x_hi = mx > sx + xt;
         ey_lo = (sy - my) / yd;
         ey_hi = (my - sy) / yd;
         ex_lo = (sx - mx) / xd;
         ex_hi = (mx - sx) / xd;
         case (t.phase)
            Phase1: begin
               if (y_lo) begin
                  b = b0 - ey_lo;
                  code = Phase3;
               end else if (x_lo) begin
                  r = r0 + ex_lo;
                  if (r >= RedBlueCap) begin
                     r = RedBlueCap;
                     code = Phase2;
                  end
               end else if (x_hi) begin
                  r = r0 - ex_hi;
               end else begin
                  code = Phase2;
               end
            end
            Phase2: begin
               if (g > GreenCap) g = GreenCap;
               if (y_lo) g = g + ey_lo;
               else if (y_hi) g = g - ey_hi;
               if (x_hi) begin
                  r = r - ex_hi;
               end else if (x_lo) begin
                  r = r + ex_lo;
                  if (r >= RedBlueCap) begin
                     r = RedBlueCap;
                     code = Phase4;
                     b = b0 - ex_lo;
                  end
               end
            end
            Phase3: begin
               if (y_lo) begin
                  b = b0 - ey_lo;
               end else if (y_hi) begin
                  b = b0 + ey_hi;
                  if (b >= RedBlueCap) begin
                     b = RedBlueCap;
                     code = Phase1;
                  end
               end else if (x_hi) begin
                  r = r0 - ex_hi;
               end else if (x_lo) begin
                  r = r0 + ex_lo;
                  if (r >= RedBlueCap) begin
                     r = RedBlueCap;
                     code = Phase4;
                     b = b0 - ex_lo;
                  end
               end
            end
            default: begin
               if (x_lo) begin
                  b = b0 - ex_lo;
               end else if (x_hi) begin
                  b = b0 + ex_hi;
               end else begin
                  if (y_lo) begin
                     g = g + ey_lo;
                     if (g > GreenCap) g = GreenCap;
                  end else if (y_hi) begin
                     g = g - ey_hi;
                  end
                  code = Phase2;
               end
            end
         endcase
         gain_red   = 8'(clamp_red_blue(r));
         gain_blue  = 8'(clamp_red_blue(b));
         gain_green = (g < 0) ? 8'd0 : (g > 255) ? 8'd255 : 8'(g);
      end
      advised_phase = code;
      return '{gain_red, gain_green, gain_blue, code};
   endfunction

   function automatic logic [15:0] near_target(logic [15:0] centre, logic [15:0] tol,
                                              logic [15:0] divisor);
      int off, v;
      case ($urandom_range(0, 9))
         0, 1, 2: off = int'($urandom_range(0, int'(tol)));
         3, 4, 5: off = int'(tol) + 1 + int'($urandom_range(0, 4 * int'(divisor) + 4));
         6, 7, 8: off = int'(tol) + int'($urandom_range(0, 3000));
         default: return 16'($urandom);
      endcase
      v = ($urandom_range(0, 1) == 1) ? int'(centre) + off : int'(centre) - off;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return 16'(v);
   endfunction

   function automatic logic [7:0] preset_gain();
      return ($urandom_range(0, 1) == 1) ? 8'($urandom) : 8'($urandom_range(100, 160));
   endfunction

   task automatic report_mismatch(string what);
      if (mismatch_count < 100) $display("%0t: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic send_request(gain_req_type t, bit known, gain_rsp_type want);
      gain_rsp_type predicted;
      @(negedge clock);
      csr_valid <= 1'b0;
      while (take_break()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= t.mode;
      req_phase        <= t.phase;
      req_measured_x   <= t.measured_x;
      req_measured_y   <= t.measured_y;
      req_preset_red   <= t.preset_red;
      req_preset_green <= t.preset_green;
      req_preset_blue  <= t.preset_blue;
      do @(posedge clock); while (req_stall);
      predicted = step_gains(t);
      gains_due.push_back(known ? want : predicted);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [15:0] data);
      @(negedge clock);
      while (take_break()) begin
         csr_valid <= 1'b0;
         @(negedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         RegTargetX:    cfg_target_x = data;
         RegTargetY:    cfg_target_y = data;
         RegToleranceX: cfg_tol_x = data;
         RegToleranceY: cfg_tol_y = data;
         RegXStepDiv:   cfg_x_div = data;
         RegYStepDiv:   cfg_y_div = data;
         RegGainMin:    cfg_gain_min = data[7:0];
         RegGainMax:    cfg_gain_max = data[7:0];
         default: ;
      endcase
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      while (gains_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   always @(negedge clock) begin
      rsp_stall <= take_break();
   end

   always @(posedge clock) begin : check_results
      gain_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (gains_due.size() == 0) begin
            report_mismatch($sformatf("result %0d/%0d/%0d phase %0d with none outstanding",
               rsp_red_out, rsp_green_out, rsp_blue_out, rsp_next_phase));
         end else begin
            want = gains_due.pop_front();
            if (rsp_red_out !== want.red)
               report_mismatch($sformatf("red_out %0d, expected %0d", rsp_red_out, want.red));
            if (rsp_green_out !== want.green)
               report_mismatch($sformatf("green_out %0d, expected %0d",
                  rsp_green_out, want.green));
            if (rsp_blue_out !== want.blue)
               report_mismatch($sformatf("blue_out %0d, expected %0d",
                  rsp_blue_out, want.blue));
            if (rsp_next_phase !== want.phase)
               report_mismatch($sformatf("next_phase %0d, expected %0d",
                  rsp_next_phase, want.phase));
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WatchdogLimit) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      gain_req_type t;
      int sent;
      logic [15:0] data;
      setting_regs[0] = '{16'd2800, 16'd2900, 16'd10, 16'd10, 16'd4, 16'd4, 16'd0, 16'd255};
      setting_regs[1] = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd255};
      setting_regs[2] = '{16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF,
                          16'd255, 16'd255};
      setting_regs[3] = '{16'd3000, 16'd3100, 16'd5, 16'd5, 16'd1, 16'd1, 16'd200, 16'd50};
      setting_regs[4] = '{16'd2800, 16'd2900, 16'd10, 16'd10, 16'd2, 16'd3, 16'd100, 16'd120};
      setting_regs[5] = '{16'($urandom_range(1000, 6000)), 16'($urandom_range(1000, 6000)),
                          16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                          16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)),
                          16'($urandom_range(0, 80)), 16'($urandom_range(130, 255))};
      for (int r = 0; r < 8; r++) setting_regs[6][r] = 16'($urandom);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 25; i++)
         send_request(DirectedRows[i].req, DirectedRows[i].known, DirectedRows[i].rsp);
      drain_results();

      for (int s = 0; s < NumSettings; s++) begin
         steady_flow = (s == 4);
         for (int r = 0; r < 8; r++) begin
            data = setting_regs[s][r];
            if (RegOrder[r] == RegGainMin || RegOrder[r] == RegGainMax)
               data = {8'($urandom), data[7:0]};
            write_csr(RegOrder[r], data);
         end
         sent = 0;
         while (sent < ItemsPerSetting) begin
            if ($urandom_range(0, 99) < 12) begin
               t.mode         = 1'($urandom);
               t.phase        = 3'($urandom);
               t.measured_x   = 16'($urandom);
               t.measured_y   = 16'($urandom);
               t.preset_red   = 8'($urandom);
               t.preset_green = 8'($urandom);
               t.preset_blue  = 8'($urandom);
               send_request(t, 1'b0, '0);
               sent++;
            end else begin
               t.mode         = 1'b0;
               t.phase        = 3'($urandom_range(1, 4));
               t.measured_x   = 16'($urandom);
               t.measured_y   = 16'($urandom);
               t.preset_red   = preset_gain();
               t.preset_green = preset_gain();
               t.preset_blue  = preset_gain();
               send_request(t, 1'b0, '0);
               sent++;
               repeat ($urandom_range(2, 12)) begin
                  t.mode  = 1'b1;
                  t.phase = ($urandom_range(0, 9) == 0) ? 3'($urandom) : advised_phase;
                  t.measured_x   = near_target(cfg_target_x, cfg_tol_x, cfg_x_div);
                  t.measured_y   = near_target(cfg_target_y, cfg_tol_y, cfg_y_div);
                  t.preset_red   = 8'($urandom);
                  t.preset_green = 8'($urandom);
                  t.preset_blue  = 8'($urandom);
                  send_request(t, 1'b0, '0);
                  sent++;
               end
            end
         end
         drain_results();
      end
      steady_flow = 1'b0;

      repeat (50) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
